// ===== hw/rtl/sgls_pkg.sv =====
// Shared widths, part codes and word types for the scatter-gather list splitter.
`default_nettype none

package sgls_pkg;

  localparam int BaseW  = 64;
  localparam int LenW   = 32;
  localparam int OffW   = 40;
  localparam int CountW = 9;

  // Largest value a count field can hold.
  localparam int CountMax = (2 ** CountW) - 1;

  localparam logic PartHead = 1'b0;
  localparam logic PartTail = 1'b1;

  typedef struct packed {
    logic [BaseW-1:0] desc_base;
    logic [LenW-1:0]  desc_length;
    logic [OffW-1:0]  split_offset;
    logic             first_desc;
    logic             last_desc;
  } sgls_item_t;

  typedef struct packed {
    logic              part;
    logic [BaseW-1:0]  out_base;
    logic [LenW-1:0]   out_length;
    logic              last_of_item;
    logic              list_done;
    logic [CountW-1:0] head_count;
    logic [CountW-1:0] tail_count;
  } sgls_res_t;

  // One or two output words produced by a single descriptor.
  typedef struct packed {
    logic      two;
    sgls_res_t r0;
    sgls_res_t r1;
  } sgls_pair_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgls_if.sv =====
// Valid/ready channel interfaces for descriptor words and part words.
`default_nettype none

interface sgls_desc_if;
  logic                        valid;
  logic                        ready;
  logic [sgls_pkg::BaseW-1:0]  desc_base;
  logic [sgls_pkg::LenW-1:0]   desc_length;
  logic [sgls_pkg::OffW-1:0]   split_offset;
  logic                        first_desc;
  logic                        last_desc;

  modport source (
    output valid, desc_base, desc_length, split_offset, first_desc, last_desc,
    input  ready
  );
  modport sink (
    input  valid, desc_base, desc_length, split_offset, first_desc, last_desc,
    output ready
  );
endinterface

interface sgls_part_if;
  logic                        valid;
  logic                        ready;
  logic                        part;
  logic [sgls_pkg::BaseW-1:0]  out_base;
  logic [sgls_pkg::LenW-1:0]   out_length;
  logic                        last_of_item;
  logic                        list_done;
  logic [sgls_pkg::CountW-1:0] head_count;
  logic [sgls_pkg::CountW-1:0] tail_count;

  modport source (
    output valid, part, out_base, out_length, last_of_item, list_done,
           head_count, tail_count,
    input  ready
  );
  modport sink (
    input  valid, part, out_base, out_length, last_of_item, list_done,
           head_count, tail_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/scatter_gather_list_splitter.sv =====
// Top level of the scatter-gather list splitter.
// Descriptors (base, length) enter on descs and leave on parts as head parts
// (before the split offset) and tail parts (from the offset on); the offset is
// taken with the word marked first_desc. A descriptor is taken every cycle as
// long as the output side takes a word every cycle: the one descriptor that
// straddles the offset gives two words (head, then tail); the second buffer slot
// soaks up the extra word, and the input is held when another two-word
// descriptor arrives before that slot has drained. A descriptor passes through
// an input register, the split logic, then the result buffer. The closing word
// of a list (list_done) carries the head and tail counts, saturating at
// MAX_DESCRIPTORS and MAX_DESCRIPTORS + 1, each capped at CountMax.
`default_nettype none

module scatter_gather_list_splitter
  import sgls_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = 256
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sgls_desc_if.sink   descs,
  sgls_part_if.source parts
);

  logic       item_valid;
  logic       item_valid_next;
  sgls_item_t item;
  sgls_pair_t pair;
  logic       push_ready;
  logic       take;
  logic       load;

  assign take        = item_valid && push_ready;
  assign descs.ready = !item_valid || take;
  assign load        = descs.valid && descs.ready;

  always_comb begin
    item_valid_next = item_valid;
    if (load) begin
      item_valid_next = 1'b1;
    end else if (take) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.desc_base    <= descs.desc_base;
      item.desc_length  <= descs.desc_length;
      item.split_offset <= descs.split_offset;
      item.first_desc   <= descs.first_desc;
      item.last_desc    <= descs.last_desc;
    end
  end

  sgls_split #(
    .MAX_DESCRIPTORS(MAX_DESCRIPTORS)
  ) u_split (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .pair (pair)
  );

  sgls_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .push_valid (item_valid),
    .push_ready (push_ready),
    .parts      (parts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sgls_split.sv =====
// Split decision for one descriptor, with the seek offset and part counters.
`default_nettype none

module sgls_split
  import sgls_pkg::*;
#(
  parameter int MAX_DESCRIPTORS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sgls_item_t item,
  input  wire logic       take,
  output sgls_pair_t      pair
);

  localparam int HeadCapInt = (MAX_DESCRIPTORS < CountMax) ? MAX_DESCRIPTORS : CountMax;
  localparam int TailCapInt = (MAX_DESCRIPTORS + 1 < CountMax) ? MAX_DESCRIPTORS + 1
                                                                : CountMax;
  localparam logic [CountW-1:0] HeadCap = CountW'(HeadCapInt);
  localparam logic [CountW-1:0] TailCap = CountW'(TailCapInt);

  logic [OffW-1:0]   remaining_offset;
  logic              in_tail_phase;
  logic [CountW-1:0] heads_seen;
  logic [CountW-1:0] tails_seen;

  logic [OffW-1:0]   remaining_offset_next;
  logic              in_tail_phase_next;
  logic [CountW-1:0] heads_seen_next;
  logic [CountW-1:0] tails_seen_next;

  logic [OffW-1:0]   eff_off;
  logic              tail_now;
  logic [CountW-1:0] heads0;
  logic [CountW-1:0] tails0;
  logic [OffW-1:0]   len_ext;
  logic              below;
  logic [LenW-1:0]   rest;
  logic [BaseW-1:0]  cut_base;

  always_comb begin
    eff_off  = item.first_desc ? item.split_offset : remaining_offset;
    tail_now = item.first_desc ? 1'b0 : in_tail_phase;
    if (eff_off == '0) begin
      tail_now = 1'b1;
    end
    heads0   = item.first_desc ? '0 : heads_seen;
    tails0   = item.first_desc ? '0 : tails_seen;
    len_ext  = {{(OffW-LenW){1'b0}}, item.desc_length};
    below    = len_ext < eff_off;
    // only used when the descriptor covers the offset, so eff_off fits LenW
    rest     = item.desc_length - eff_off[LenW-1:0];
    cut_base = item.desc_base + {{(BaseW-OffW){1'b0}}, eff_off};
  end

  always_comb begin
    pair                  = '0;
    heads_seen_next       = heads0;
    tails_seen_next       = tails0;
    remaining_offset_next = '0;
    in_tail_phase_next    = 1'b1;

    if (tail_now) begin
      pair.r0.part       = PartTail;
      pair.r0.out_base   = item.desc_base;
      pair.r0.out_length = item.desc_length;
      if (tails0 < TailCap) begin
        tails_seen_next = tails0 + CountW'(1);
      end
    end else if (below) begin
      pair.r0.part          = PartHead;
      pair.r0.out_base      = item.desc_base;
      pair.r0.out_length    = item.desc_length;
      remaining_offset_next = eff_off - len_ext;
      in_tail_phase_next    = 1'b0;
      if (heads0 < HeadCap) begin
        heads_seen_next = heads0 + CountW'(1);
      end
    end else begin
      pair.r0.part       = PartHead;
      pair.r0.out_base   = item.desc_base;
      pair.r0.out_length = eff_off[LenW-1:0];
      if (heads0 < HeadCap) begin
        heads_seen_next = heads0 + CountW'(1);
      end
      if (rest != '0) begin
        pair.two           = 1'b1;
        pair.r1.part       = PartTail;
        pair.r1.out_base   = cut_base;
        pair.r1.out_length = rest;
        if (tails0 < TailCap) begin
          tails_seen_next = tails0 + CountW'(1);
        end
      end
    end

    // tag the closing word of this descriptor
    if (pair.two) begin
      pair.r1.last_of_item = 1'b1;
      if (item.last_desc) begin
        pair.r1.list_done  = 1'b1;
        pair.r1.head_count = heads_seen_next;
        pair.r1.tail_count = tails_seen_next;
      end
    end else begin
      pair.r0.last_of_item = 1'b1;
      if (item.last_desc) begin
        pair.r0.list_done  = 1'b1;
        pair.r0.head_count = heads_seen_next;
        pair.r0.tail_count = tails_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_offset <= '0;
      in_tail_phase    <= 1'b0;
      heads_seen       <= '0;
      tails_seen       <= '0;
    end else if (take) begin
      remaining_offset <= remaining_offset_next;
      in_tail_phase    <= in_tail_phase_next;
      heads_seen       <= heads_seen_next;
      tails_seen       <= tails_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgls_out_buf.sv =====
// Two-word result buffer: takes one or two words per descriptor, sends one per cycle while parts.ready is high.
`default_nettype none

module sgls_out_buf
  import sgls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire sgls_pair_t pair,
  input  wire logic       push_valid,
  output logic            push_ready,
  sgls_part_if.source     parts
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  sgls_res_t  slot0;
  sgls_res_t  slot1;
  sgls_res_t  slot0_next;
  sgls_res_t  slot1_next;

  logic       pop;
  logic       push;
  logic [1:0] cnt_left;
  logic [1:0] n;
  logic [2:0] fill;

  assign parts.valid        = cnt != 2'd0;
  assign parts.part         = slot0.part;
  assign parts.out_base     = slot0.out_base;
  assign parts.out_length   = slot0.out_length;
  assign parts.last_of_item = slot0.last_of_item;
  assign parts.list_done    = slot0.list_done;
  assign parts.head_count   = slot0.head_count;
  assign parts.tail_count   = slot0.tail_count;

  assign pop        = (cnt != 2'd0) && parts.ready;
  assign cnt_left   = cnt - {1'b0, pop};
  assign n          = pair.two ? 2'd2 : 2'd1;
  assign fill       = {1'b0, cnt_left} + {1'b0, n};
  assign push_ready = fill <= 3'd2;
  assign push       = push_valid && push_ready;

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    if (pop && (cnt == 2'd2)) begin
      slot0_next = slot1;
    end
    if (push) begin
      if (cnt_left == 2'd0) begin
        slot0_next = pair.r0;
        slot1_next = pair.r1;
      end else begin
        slot1_next = pair.r0;
      end
    end
    cnt_next = push ? fill[1:0] : cnt_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

`default_nettype wire
